// ----- src/dgpe_pkg.sv -----
// Shared types and constants of the dual-gradient pixel energy block.
// No dependencies; imported by dgpe_grad_acc and the top level of the block.
`default_nettype none

package dgpe_pkg;

  localparam int CHAN_W   = 8;
  localparam int PIX_W    = 3 * CHAN_W;
  localparam int COORD_W  = 6;
  localparam int SIZE_W   = 7;
  localparam int ENERGY_W = 19;
  localparam int MIN_SPAN = 3;

  // Request kinds carried in s_tuser.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Register selector: bit 2 of the byte address.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  // Control of the shared squared-difference accumulator.
  typedef struct packed {
    logic clear;
    logic step;
  } acc_ctrl_t;

endpackage

`default_nettype wire

// ----- src/dgpe_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module dgpe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/dgpe_grad_acc.sv -----
// Shared unit: squares the difference of one colour channel pair and adds it
// to a running energy sum. Depends on dgpe_pkg.
`default_nettype none

module dgpe_grad_acc
  import dgpe_pkg::*;
(
  input  wire logic                clk,
  input  wire acc_ctrl_t           ctrl,
  input  wire logic [CHAN_W-1:0]   chan_a,
  input  wire logic [CHAN_W-1:0]   chan_b,
  output logic      [ENERGY_W-1:0] energy
);

  logic [CHAN_W-1:0]   diff;
  logic [2*CHAN_W-1:0] square;

  always_comb begin
    diff   = (chan_a > chan_b) ? (chan_a - chan_b) : (chan_b - chan_a);
    square = diff * diff;
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      energy <= '0;
    end else if (ctrl.step) begin
      energy <= energy + ENERGY_W'(square);
    end
  end

endmodule

`default_nettype wire

// ----- src/dual_gradient_pixel_energy.sv -----
// Top level of the dual-gradient pixel energy block: pixel store, sequencer,
// configuration registers and output register. Depends on dgpe_pkg,
// dgpe_ram and dgpe_grad_acc.
`default_nettype none

// The block keeps an RGB image of up to MAX_WIDTH x MAX_HEIGHT pixels in a
// single-port RAM. A write request (s_tuser = 0) stores one pixel as it is
// taken, without further steps; it gives no result, and a write outside the
// configured size is dropped. A query request (s_tuser = 1) returns the
// dual-gradient energy of one pixel: the summed squared colour differences of
// its left and right neighbours plus those of its upper and lower neighbours,
// with wrap-around at the configured image edges. An axis shorter than three
// pixels contributes nothing. A query outside the configured size returns
// energy 0 with the bad-coordinate flag set. A query blocks the input once
// taken: for each axis in use the neighbour pair is read through the one RAM
// port and the single squared-difference unit handles blue, green and red in
// turn, then the output register is loaded. A bad query, or one on an image
// narrow and short at once, goes straight from being taken to the output
// register load, skipping the reads. In either case the final load
// waits, and the input stays blocked, for as long as the output register
// still holds an earlier result that has not been taken. The result waits in
// the output register, and a new request is taken meanwhile. The pixel store
// is not cleared: a query whose neighbours were never written returns an
// undefined energy. Configuration registers (width at byte address 0, height
// at 4) must only be written while no query is in progress; zero acts as one
// and values above the maximum saturate.
module dual_gradient_pixel_energy
  import dgpe_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Request stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // From bit 0: col[5:0], row[11:6], red[19:12], green[27:20], blue[35:28],
  // zero padding[39:36].
  input  wire logic [39:0] s_tdata,
  // Bit 0: func (0 write, 1 query).
  input  wire logic [0:0]  s_tuser,
  // Result stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // From bit 0: pixel_energy[18:0], zero padding[23:19].
  output logic [23:0]      m_tdata,
  // Bit 0: bad_coordinate.
  output logic [0:0]       m_tuser,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Widths for size arithmetic: wide enough for both the register and the
  // maximum itself.
  localparam int XW    = ($clog2(MAX_WIDTH + 1) > SIZE_W) ? $clog2(MAX_WIDTH + 1) : SIZE_W;
  localparam int YW    = ($clog2(MAX_HEIGHT + 1) > SIZE_W) ? $clog2(MAX_HEIGHT + 1) : SIZE_W;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD_A = 5'b00010,
    S_RD_B = 5'b00100,
    S_CH   = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  function automatic logic [AW-1:0] pix_addr(input logic [ROW_W-1:0] r,
                                             input logic [COL_W-1:0] c);
    return AW'(r) * AW'(MAX_WIDTH) + AW'(c);
  endfunction

  // Configuration registers.
  logic [SIZE_W-1:0] image_width;
  logic [SIZE_W-1:0] image_height;

  // Sequencer state.
  state_t            state;
  state_t            state_next;
  logic              pair;        // 0: horizontal pair, 1: vertical pair
  logic              pair_next;
  logic [1:0]        chan;
  logic              do_vert;
  logic              bad_q;
  logic [AW-1:0]     addr_left;
  logic [AW-1:0]     addr_right;
  logic [AW-1:0]     addr_up;
  logic [AW-1:0]     addr_down;
  logic [PIX_W-1:0]  pix_a;

  // Decoded request.
  logic [COORD_W-1:0] in_col;
  logic [COORD_W-1:0] in_row;
  logic [PIX_W-1:0]   in_pix;
  logic               in_accept;
  logic [XW-1:0]      w_eff;
  logic [YW-1:0]      h_eff;
  logic [XW-1:0]      col_x;
  logic [YW-1:0]      row_y;
  logic [XW-1:0]      left_x;
  logic [XW-1:0]      right_x;
  logic [YW-1:0]      up_y;
  logic [YW-1:0]      down_y;
  logic               in_bad;
  logic               in_horiz;
  logic               in_vert;

  // Memory port.
  logic               mem_en;
  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [PIX_W-1:0]   mem_rdata;

  // Shared unit.
  acc_ctrl_t          acc_ctrl;
  logic [CHAN_W-1:0]  chan_a;
  logic [CHAN_W-1:0]  chan_b;
  logic [ENERGY_W-1:0] energy;

  logic               out_load;

  assign pready   = 1'b1;
  assign s_tready = (state == S_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign in_col   = s_tdata[5:0];
  assign in_row   = s_tdata[11:6];
  assign in_pix   = s_tdata[35:12];

  // Configuration writes and reads.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SIZE_RESET;
      image_height <= SIZE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_WIDTH:  image_width  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT: image_height <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = 32'(image_width);
      REG_HEIGHT: prdata = 32'(image_height);
      default:    prdata = '0;
    endcase
  end

  // Effective size, bounds check and wrapped neighbour coordinates. A zero
  // size register acts as one; anything above the maximum saturates.
  always_comb begin
    if (image_width == '0) begin
      w_eff = XW'(1);
    end else if (XW'(image_width) > XW'(MAX_WIDTH)) begin
      w_eff = XW'(MAX_WIDTH);
    end else begin
      w_eff = XW'(image_width);
    end
    if (image_height == '0) begin
      h_eff = YW'(1);
    end else if (YW'(image_height) > YW'(MAX_HEIGHT)) begin
      h_eff = YW'(MAX_HEIGHT);
    end else begin
      h_eff = YW'(image_height);
    end

    col_x    = XW'(in_col);
    row_y    = YW'(in_row);
    in_bad   = (col_x >= w_eff) || (row_y >= h_eff);
    in_horiz = (w_eff >= XW'(MIN_SPAN));
    in_vert  = (h_eff >= YW'(MIN_SPAN));

    left_x  = (col_x == '0) ? (w_eff - XW'(1)) : (col_x - XW'(1));
    right_x = (col_x == (w_eff - XW'(1))) ? '0 : (col_x + XW'(1));
    up_y    = (row_y == '0) ? (h_eff - YW'(1)) : (row_y - YW'(1));
    down_y  = (row_y == (h_eff - YW'(1))) ? '0 : (row_y + YW'(1));
  end

  // Sequencer: next state and memory port selection.
  always_comb begin
    state_next = state;
    pair_next  = pair;
    mem_en     = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = pix_addr(ROW_W'(row_y), COL_W'(col_x));
    acc_ctrl   = '0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          if (s_tuser[0] == FUNC_WRITE) begin
            mem_en = !in_bad;
            mem_we = !in_bad;
          end else begin
            acc_ctrl.clear = 1'b1;
            if (in_bad) begin
              state_next = S_DONE;
            end else if (in_horiz) begin
              pair_next  = 1'b0;
              state_next = S_RD_A;
            end else if (in_vert) begin
              pair_next  = 1'b1;
              state_next = S_RD_A;
            end else begin
              state_next = S_DONE;
            end
          end
        end
      end
      S_RD_A: begin
        mem_en     = 1'b1;
        mem_addr   = pair ? addr_up : addr_left;
        state_next = S_RD_B;
      end
      S_RD_B: begin
        mem_en     = 1'b1;
        mem_addr   = pair ? addr_down : addr_right;
        state_next = S_CH;
      end
      S_CH: begin
        acc_ctrl.step = 1'b1;
        if (chan == 2'd2) begin
          if (!pair && do_vert) begin
            pair_next  = 1'b1;
            state_next = S_RD_A;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Channel selection for the shared unit: blue, green, then red.
  always_comb begin
    unique case (chan)
      2'd0: begin
        chan_a = pix_a[23:16];
        chan_b = mem_rdata[23:16];
      end
      2'd1: begin
        chan_a = pix_a[15:8];
        chan_b = mem_rdata[15:8];
      end
      default: begin
        chan_a = pix_a[7:0];
        chan_b = mem_rdata[7:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pair  <= 1'b0;
      chan  <= '0;
    end else begin
      state <= state_next;
      pair  <= pair_next;
      if (state == S_CH) begin
        chan <= (chan == 2'd2) ? 2'd0 : (chan + 2'd1);
      end
    end
  end

  // Query context, captured when the request is taken.
  always_ff @(posedge clk) begin
    if (in_accept && (s_tuser[0] == FUNC_QUERY)) begin
      bad_q      <= in_bad;
      do_vert    <= in_vert;
      addr_left  <= pix_addr(ROW_W'(row_y), COL_W'(left_x));
      addr_right <= pix_addr(ROW_W'(row_y), COL_W'(right_x));
      addr_up    <= pix_addr(ROW_W'(up_y), COL_W'(col_x));
      addr_down  <= pix_addr(ROW_W'(down_y), COL_W'(col_x));
    end
    // First pixel of the pair arrives from the RAM while the second is read.
    if (state == S_RD_B) begin
      pix_a <= mem_rdata;
    end
  end

  // Output register: the result waits here while the next request is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= 24'(energy);
      m_tuser <= bad_q;
    end
  end

  dgpe_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_pixel_store (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (in_pix),
    .rdata (mem_rdata)
  );

  dgpe_grad_acc u_grad_acc (
    .clk    (clk),
    .ctrl   (acc_ctrl),
    .chan_a (chan_a),
    .chan_b (chan_b),
    .energy (energy)
  );

  // A bad coordinate never carries energy.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[ENERGY_W-1:0] == '0))
    else $error("bad coordinate result with non-zero energy");

  // The RAM is written only when a write request is taken in idle.
  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (in_accept && (state == S_IDLE) && (s_tuser[0] == FUNC_WRITE)))
    else $error("pixel store written outside a write request");

  // The channel counter walks all three colours before leaving S_CH.
  assert property (@(posedge clk) disable iff (rst)
    ((state == S_CH) && (chan != 2'd2)) |=> (state == S_CH))
    else $error("channel loop left early");

  assert property (@(posedge clk) disable iff (rst)
    chan != 2'd3)
    else $error("channel counter out of range");

  // A query blocks the input until its result is in the output register.
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && (s_tuser[0] == FUNC_QUERY)) |=> !s_tready)
    else $error("input ready during a query");

endmodule

`default_nettype wire

// ----- tb/energy_checker.sv -----
`timescale 1ns / 100ps
// Checker for the dual-gradient pixel energy block: keeps its own image copy and size
// registers, predicts each query result and compares it with the result stream.
// Depends on dgpe_pkg for widths, request kinds and register selectors.

module energy_checker
  import dgpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic [0:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic [0:0]  m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [ENERGY_W-1:0] energy;
    logic                bad;
  } energy_result_t;

  logic [PIX_W-1:0]  image_copy [64*64];
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  energy_result_t    energy_due [$];
  int                fails;

  function automatic logic [SIZE_W-1:0] span(logic [SIZE_W-1:0] v);
    if (v == 0) return 1;
    if (v > 64) return 64;
    return v;
  endfunction

  function automatic logic [15:0] sq_diff(logic [7:0] a, logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? a - b : b - a;
    return 16'(d) * 16'(d);
  endfunction

  function automatic logic [17:0] colour_grad(logic [23:0] p, logic [23:0] q);
    return 18'(sq_diff(p[23:16], q[23:16])) + 18'(sq_diff(p[15:8], q[15:8]))
         + 18'(sq_diff(p[7:0], q[7:0]));
  endfunction

  function automatic energy_result_t energy_of(logic [5:0] col, logic [5:0] row);
    energy_result_t res;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    int lo;
    int hi;
    w = span(width_reg);
    h = span(height_reg);
    res.bad = (col >= w) || (row >= h);
    res.energy = '0;
    if (!res.bad) begin
      // Neighbours wrap at the edges of the image in use, not of the store.
      if (w >= MIN_SPAN) begin
        lo = (col == 0) ? w - 1 : col - 1;
        hi = (col == w - 1) ? 0 : col + 1;
        res.energy += 19'(colour_grad(image_copy[row*64 + lo], image_copy[row*64 + hi]));
      end
      if (h >= MIN_SPAN) begin
        lo = (row == 0) ? h - 1 : row - 1;
        hi = (row == h - 1) ? 0 : row + 1;
        res.energy += 19'(colour_grad(image_copy[lo*64 + col], image_copy[hi*64 + col]));
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = SIZE_RESET;
      height_reg = SIZE_RESET;
      energy_due.delete();
      fails = 0;
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (energy_due.size() == 0) begin
          $display("%0t: result with no query waiting: energy %0d bad %0d", $time,
                   m_tdata, m_tuser[0]);
          fails++;
        end else begin
          energy_result_t want;
          want = energy_due.pop_front();
          if (m_tdata !== {5'b0, want.energy} || m_tuser[0] !== want.bad) begin
            $display("%0t: energy mismatch: expected energy %0d bad %0d, got energy %0d bad %0d",
                     $time, want.energy, want.bad, m_tdata, m_tuser[0]);
            fails++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser[0] == FUNC_QUERY) begin
          energy_due.push_back(energy_of(s_tdata[5:0], s_tdata[11:6]));
        end else if (s_tdata[5:0] < span(width_reg) && s_tdata[11:6] < span(height_reg)) begin
          // Store as {red, green, blue}; writes outside the image are dropped.
          image_copy[s_tdata[11:6]*64 + s_tdata[5:0]] =
            {s_tdata[19:12], s_tdata[27:20], s_tdata[35:28]};
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_WIDTH) width_reg = pwdata[SIZE_W-1:0];
        else height_reg = pwdata[SIZE_W-1:0];
      end
      fail_count <= fails;
      pending <= energy_due.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the testbench for the dual-gradient pixel energy block: clock, reset, requests,
// register writes and the verdict. Depends on dgpe_pkg, the block and energy_checker.

module tb_top;
  import dgpe_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // From bit 0: col[5:0], row[11:6], red[19:12], green[27:20], blue[35:28], padding[39:36].
  logic [39:0] s_tdata = '0;
  // Bit 0: func.
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // From bit 0: pixel_energy[18:0], padding[23:19].
  logic [23:0] m_tdata;
  // Bit 0: bad_coordinate.
  logic [0:0]  m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;

  // When calm is set neither side idles, which gives stretches at full rate.
  bit          calm = 1'b1;
  // The image size in effect, after the block's own clamping of the registers.
  int          cur_w = 64;
  int          cur_h = 64;
  // Store entries written so far. A query is only sent once every neighbour that
  // it reads has been written, so the store never needs a full fill.
  bit          written [64*64];
  // Requests taken by the block so far.
  int          sent_count = 0;

  always #2 clk = ~clk;

  dual_gradient_pixel_energy i_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  energy_checker i_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .pending
  );

  // Gaps are mostly absent or short, with the occasional long one.
  function automatic int gap_pick();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Colour channels lean towards the extremes so that large energies turn up often.
  function automatic logic [7:0] chan_pick();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] colour_pick();
    return {chan_pick(), chan_pick(), chan_pick()};
  endfunction

  function automatic int eff_size(int v);
    if (v == 0) return 1;
    if (v > 64) return 64;
    return v;
  endfunction

  // The result side stalls now and then on its own, independent of the requests.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) begin
          stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        end
      end
    end
  end

  // One request: an optional gap with tvalid low, then the request is held until taken.
  // tvalid is left high afterwards so back-to-back requests never drop it for a step.
  task automatic send_req(logic func, int col, int row, logic [23:0] rgb);
    int gap;
    gap = gap_pick();
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {4'b0, rgb[7:0], rgb[15:8], rgb[23:16], 6'(row), 6'(col)};
    do @(posedge clk); while (!s_tready);
    sent_count++;
    // Writes outside the image in use are dropped by the block.
    if (func == FUNC_WRITE && col < cur_w && row < cur_h) begin
      written[row * 64 + col] = 1'b1;
    end
  endtask

  // Writes every neighbour that a query at this pixel would read and that has never
  // been written.
  task automatic fill_missing(int col, int row);
    int nc [4];
    int nr [4];
    int n;
    n = 0;
    if (col < cur_w && row < cur_h) begin
      if (cur_w >= MIN_SPAN) begin
        nc[n] = (col == 0) ? cur_w - 1 : col - 1;
        nr[n] = row;
        n++;
        nc[n] = (col == cur_w - 1) ? 0 : col + 1;
        nr[n] = row;
        n++;
      end
      if (cur_h >= MIN_SPAN) begin
        nc[n] = col;
        nr[n] = (row == 0) ? cur_h - 1 : row - 1;
        n++;
        nc[n] = col;
        nr[n] = (row == cur_h - 1) ? 0 : row + 1;
        n++;
      end
    end
    for (int k = 0; k < n; k++) begin
      if (!written[nr[k] * 64 + nc[k]]) begin
        send_req(FUNC_WRITE, nc[k], nr[k], colour_pick());
      end
    end
  endtask

  task automatic query_req(int col, int row);
    fill_missing(col, row);
    send_req(FUNC_QUERY, col, row, colour_pick());
  endtask

  // Drops tvalid and waits until every query has been answered and the block has
  // had time to finish anything still in flight.
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic reg_write(logic sel, int value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    // The upper bits carry noise; only the low seven bits belong to the register.
    pwdata  <= {25'($urandom), 7'(value)};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_size(int wv, int hv);
    wait_idle();
    reg_write(REG_WIDTH, wv);
    reg_write(REG_HEIGHT, hv);
    cur_w = eff_size(wv);
    cur_h = eff_size(hv);
    calm = ($urandom_range(0, 3) == 0);
  endtask

  // Random requests: mostly queries, mostly inside the image, some anywhere in the store.
  // The count includes the writes that prepare a query's neighbours.
  task automatic run_random(int count);
    logic func;
    int col;
    int row;
    int target;
    target = sent_count + count;
    while (sent_count < target) begin
      func = ($urandom_range(0, 99) < 60) ? FUNC_QUERY : FUNC_WRITE;
      col = ($urandom_range(0, 99) < 85) ? $urandom_range(0, cur_w - 1) : $urandom_range(0, 63);
      row = ($urandom_range(0, 99) < 85) ? $urandom_range(0, cur_h - 1) : $urandom_range(0, 63);
      if (func == FUNC_QUERY) begin
        query_req(col, row);
      end else begin
        send_req(FUNC_WRITE, col, row, colour_pick());
      end
    end
  endtask

  initial begin
    int ws [14] = '{64, 1, 2, 3, 1, 64, 2, 64, 3, 0, 127, 65, 100, 0};
    int hs [14] = '{64, 1, 2, 3, 64, 1, 64, 2, 3, 0, 127, 64, 70, 0};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the full image. White on one side and black on the other,
    // on both axes around the corner pixel, gives the largest possible energy; the
    // corner also exercises wrap-around on both axes at once.
    calm = 1'b0;
    send_req(FUNC_WRITE, 1, 0, 24'hffffff);
    send_req(FUNC_WRITE, 63, 0, 24'h000000);
    send_req(FUNC_WRITE, 0, 1, 24'hffffff);
    send_req(FUNC_WRITE, 0, 63, 24'h000000);
    query_req(0, 0);
    query_req(63, 63);
    query_req(63, 0);
    query_req(0, 63);
    query_req(31, 17);
    // Black pixels just outside the small image below, read again once it is full size.
    send_req(FUNC_WRITE, 5, 0, 24'h000000);
    send_req(FUNC_WRITE, 0, 4, 24'h000000);

    // A small image: writes and queries just past the edge are bad coordinates,
    // and a dropped write must leave its pixel untouched for a later query.
    set_size(5, 4);
    send_req(FUNC_WRITE, 5, 0, 24'hffffff);
    send_req(FUNC_WRITE, 0, 4, 24'hffffff);
    query_req(5, 0);
    query_req(0, 4);
    query_req(63, 63);
    query_req(4, 3);
    query_req(0, 0);

    // Back at full size the dropped writes' pixels are neighbours again.
    set_size(64, 64);
    query_req(4, 0);
    query_req(0, 3);

    // Phases through the size extremes: a single pixel, the narrow and short cases
    // singly and together, the smallest spans that count, zero acting as one and
    // values above the maximum saturating; the last phase picks a random size.
    for (int p = 0; p < 14; p++) begin
      if (p == 13) set_size($urandom_range(1, 64), $urandom_range(1, 64));
      else set_size(ws[p], hs[p]);
      run_random(72);
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
